/* design/tsd_pkg.sv */
// Shared types, constants and helpers for the topic subscription dispatcher.
package tsd_pkg;

  localparam int TOPICS         = 256;
  localparam int SUBS_PER_TOPIC = 8;
  localparam int SLOTS          = TOPICS * SUBS_PER_TOPIC;
  localparam int TIDX_W         = $clog2(TOPICS);
  localparam int CNT_W          = $clog2(SUBS_PER_TOPIC + 1);
  localparam int ADDR_W         = $clog2(SLOTS);

  localparam logic [7:0] GRP_ALL = 8'h00;

  typedef enum logic [1:0] {
    ACT_SUB   = 2'd0,
    ACT_UNSUB = 2'd1,
    ACT_PUB   = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_DONE    = 3'd0,
    ST_FULL    = 3'd1,
    ST_NOTSUB  = 3'd2,
    ST_DELIV   = 3'd3,
    ST_NOMATCH = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] topic;
    logic [7:0]  requester_id;
    logic [7:0]  handler_id;
    logic [31:0] payload;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  subscriber_id;
    logic [7:0]  handler_out;
    logic [15:0] topic_out;
    logic [31:0] payload_out;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [7:0] grp;
    logic [7:0] handler;
    logic [7:0] requester;
  } slot_t;

  typedef struct packed {
    logic              slot_re;
    logic [ADDR_W-1:0] slot_raddr;
    logic              slot_we;
    logic [ADDR_W-1:0] slot_waddr;
    slot_t             slot_wdata;
    logic              cnt_re;
    logic              cnt_we;
    logic [TIDX_W-1:0] cnt_addr;
    logic [CNT_W-1:0]  cnt_wdata;
  } mem_req_t;

  typedef struct packed {
    slot_t            slot_q;
    logic [CNT_W-1:0] cnt_q;
  } mem_rsp_t;

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [TIDX_W-1:0] tidx,
                                                 input logic [CNT_W-1:0] slot);
    return ADDR_W'(tidx) * ADDR_W'(SUBS_PER_TOPIC) + ADDR_W'(slot);
  endfunction

endpackage

/* design/tsd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module tsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/tsd_store.sv */
// Subscriber slot memory and per-topic count memory with reset-cleared valid bits.
module tsd_store (
  input  logic               clk,
  input  logic               rst,
  input  tsd_pkg::mem_req_t  req,
  output tsd_pkg::mem_rsp_t  rsp
);

  logic [tsd_pkg::TOPICS-1:0] cnt_vld;
  logic                       vld_q;
  logic [tsd_pkg::CNT_W-1:0]  cnt_raw;
  logic [23:0]                slot_raw;

  tsd_ram #(
    .WIDTH(24),
    .DEPTH(tsd_pkg::SLOTS)
  ) u_slots (
    .clk  (clk),
    .we   (req.slot_we),
    .waddr(req.slot_waddr),
    .wdata(req.slot_wdata),
    .re   (req.slot_re),
    .raddr(req.slot_raddr),
    .rdata(slot_raw)
  );

  tsd_ram #(
    .WIDTH(tsd_pkg::CNT_W),
    .DEPTH(tsd_pkg::TOPICS)
  ) u_counts (
    .clk  (clk),
    .we   (req.cnt_we),
    .waddr(req.cnt_addr),
    .wdata(req.cnt_wdata),
    .re   (req.cnt_re),
    .raddr(req.cnt_addr),
    .rdata(cnt_raw)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_vld <= '0;
    end else if (req.cnt_we) begin
      cnt_vld[req.cnt_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.cnt_re) begin
      vld_q <= cnt_vld[req.cnt_addr];
    end
  end

  assign rsp.slot_q = tsd_pkg::slot_t'(slot_raw);
  assign rsp.cnt_q  = vld_q ? cnt_raw : '0;

endmodule

/* design/tsd_ctrl.sv */
// Sequencer: walks one topic's slots through the shared memory port and drives results.
module tsd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  tsd_pkg::cmd_t     cmd,
  output logic              res_valid,
  input  logic              res_stall,
  output tsd_pkg::res_t     res,
  output tsd_pkg::mem_req_t mreq,
  input  tsd_pkg::mem_rsp_t mrsp
);

  typedef enum logic [10:0] {
    S_IDLE     = 11'b00000000001,
    S_DISPATCH = 11'b00000000010,
    S_SH_RD    = 11'b00000000100,
    S_SH_WR    = 11'b00000001000,
    S_SH_NEW   = 11'b00000010000,
    S_SC_RD    = 11'b00000100000,
    S_SC_CHK   = 11'b00001000000,
    S_DEL_RD   = 11'b00010000000,
    S_DEL_WR   = 11'b00100000000,
    S_RESULT   = 11'b01000000000,
    S_FLUSH    = 11'b10000000000
  } state_t;

  state_t                      state, state_next;
  tsd_pkg::cmd_t               cmd_r, cmd_r_next;
  logic [tsd_pkg::CNT_W-1:0]   cnt, cnt_next;
  logic [tsd_pkg::CNT_W-1:0]   idx, idx_next;
  tsd_pkg::status_e            st, st_next;
  logic                        upd, upd_next;
  tsd_pkg::slot_t              pend, pend_next;
  logic                        have_pend, have_pend_next;
  tsd_pkg::res_t               res_next;
  logic                        res_valid_next;

  logic [tsd_pkg::TIDX_W-1:0]  tidx;
  logic [7:0]                  grp;
  logic                        topic_ok;
  logic                        out_free;
  logic [tsd_pkg::CNT_W:0]     idx_p1;
  logic [tsd_pkg::CNT_W:0]     idx_p2;
  logic [tsd_pkg::CNT_W:0]     cnt_ext;
  logic                        last_slot;
  logic                        grp_match;

  assign tidx      = cmd_r.topic[tsd_pkg::TIDX_W-1:0];
  assign grp       = cmd_r.topic[15:8];
  assign topic_ok  = {1'b0, cmd_r.topic[7:0]} < 9'(tsd_pkg::TOPICS);
  assign out_free  = !res_valid || !res_stall;
  assign idx_p1    = {1'b0, idx} + 1'b1;
  assign idx_p2    = {1'b0, idx} + 2'd2;
  assign cnt_ext   = {1'b0, cnt};
  assign last_slot = (idx_p1 == cnt_ext);
  assign grp_match = (grp == tsd_pkg::GRP_ALL) || (mrsp.slot_q.grp == grp);
  assign cmd_stall = (state != S_IDLE);

  always_comb begin
    state_next     = state;
    cmd_r_next     = cmd_r;
    cnt_next       = cnt;
    idx_next       = idx;
    st_next        = st;
    upd_next       = upd;
    pend_next      = pend;
    have_pend_next = have_pend;
    res_next       = res;
    res_valid_next = res_valid && res_stall;

    mreq            = '0;
    mreq.cnt_addr   = tidx;
    mreq.cnt_wdata  = cnt;
    mreq.slot_raddr = tsd_pkg::slot_addr(tidx, idx);
    mreq.slot_waddr = tsd_pkg::slot_addr(tidx, idx);
    mreq.slot_wdata = mrsp.slot_q;

    case (state)
      S_IDLE: begin
        mreq.cnt_addr  = cmd.topic[tsd_pkg::TIDX_W-1:0];
        mreq.cnt_re    = cmd_valid;
        have_pend_next = 1'b0;
        if (cmd_valid) begin
          cmd_r_next = cmd;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cnt_next = mrsp.cnt_q;
        idx_next = '0;
        upd_next = 1'b0;
        case (cmd_r.action)
          tsd_pkg::ACT_SUB: begin
            if (!topic_ok ||
                mrsp.cnt_q >= tsd_pkg::CNT_W'(tsd_pkg::SUBS_PER_TOPIC)) begin
              st_next    = tsd_pkg::ST_FULL;
              state_next = S_RESULT;
            end else begin
              idx_next   = mrsp.cnt_q;
              state_next = (mrsp.cnt_q == '0) ? S_SH_NEW : S_SH_RD;
            end
          end
          tsd_pkg::ACT_UNSUB: begin
            if (!topic_ok || mrsp.cnt_q == '0) begin
              st_next    = tsd_pkg::ST_NOTSUB;
              state_next = S_RESULT;
            end else begin
              state_next = S_SC_RD;
            end
          end
          tsd_pkg::ACT_PUB: begin
            state_next = (!topic_ok || mrsp.cnt_q == '0) ? S_FLUSH : S_SC_RD;
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_SH_RD: begin
        mreq.slot_re    = 1'b1;
        mreq.slot_raddr = tsd_pkg::slot_addr(tidx, idx - 1'b1);
        state_next      = S_SH_WR;
      end
      S_SH_WR: begin
        mreq.slot_we = 1'b1;
        idx_next     = idx - 1'b1;
        state_next   = (idx == tsd_pkg::CNT_W'(1)) ? S_SH_NEW : S_SH_RD;
      end
      S_SH_NEW: begin
        mreq.slot_we    = 1'b1;
        mreq.slot_waddr = tsd_pkg::slot_addr(tidx, '0);
        mreq.slot_wdata = '{grp: grp, handler: cmd_r.handler_id,
                            requester: cmd_r.requester_id};
        cnt_next        = cnt + 1'b1;
        st_next         = tsd_pkg::ST_DONE;
        upd_next        = 1'b1;
        state_next      = S_RESULT;
      end
      S_SC_RD: begin
        mreq.slot_re = 1'b1;
        state_next   = S_SC_CHK;
      end
      S_SC_CHK: begin
        if (cmd_r.action == tsd_pkg::ACT_UNSUB) begin
          if (mrsp.slot_q.requester == cmd_r.requester_id) begin
            if (last_slot) begin
              cnt_next   = cnt - 1'b1;
              st_next    = tsd_pkg::ST_DONE;
              upd_next   = 1'b1;
              state_next = S_RESULT;
            end else begin
              state_next = S_DEL_RD;
            end
          end else if (last_slot) begin
            st_next    = tsd_pkg::ST_NOTSUB;
            state_next = S_RESULT;
          end else begin
            idx_next   = idx + 1'b1;
            state_next = S_SC_RD;
          end
        end else if (!(grp_match && have_pend && !out_free)) begin
          if (grp_match) begin
            if (have_pend) begin
              res_next       = '{status: tsd_pkg::ST_DELIV, subscriber_id: pend.requester,
                                 handler_out: pend.handler, topic_out: cmd_r.topic,
                                 payload_out: cmd_r.payload, last: 1'b0};
              res_valid_next = 1'b1;
            end
            pend_next      = mrsp.slot_q;
            have_pend_next = 1'b1;
          end
          if (last_slot) begin
            state_next = S_FLUSH;
          end else begin
            idx_next   = idx + 1'b1;
            state_next = S_SC_RD;
          end
        end
      end
      S_DEL_RD: begin
        mreq.slot_re    = 1'b1;
        mreq.slot_raddr = tsd_pkg::slot_addr(tidx, idx + 1'b1);
        state_next      = S_DEL_WR;
      end
      S_DEL_WR: begin
        mreq.slot_we = 1'b1;
        idx_next     = idx + 1'b1;
        if (idx_p2 < cnt_ext) begin
          state_next = S_DEL_RD;
        end else begin
          cnt_next   = cnt - 1'b1;
          st_next    = tsd_pkg::ST_DONE;
          upd_next   = 1'b1;
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          res_next       = '{status: st, subscriber_id: 8'd0, handler_out: 8'd0,
                             topic_out: 16'd0, payload_out: 32'd0, last: 1'b1};
          res_valid_next = 1'b1;
          mreq.cnt_we    = upd;
          upd_next       = 1'b0;
          state_next     = S_IDLE;
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          if (have_pend) begin
            res_next = '{status: tsd_pkg::ST_DELIV, subscriber_id: pend.requester,
                         handler_out: pend.handler, topic_out: cmd_r.topic,
                         payload_out: cmd_r.payload, last: 1'b1};
          end else begin
            res_next = '{status: tsd_pkg::ST_NOMATCH, subscriber_id: 8'd0,
                         handler_out: 8'd0, topic_out: cmd_r.topic,
                         payload_out: cmd_r.payload, last: 1'b1};
          end
          res_valid_next = 1'b1;
          have_pend_next = 1'b0;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      have_pend <= 1'b0;
      upd       <= 1'b0;
    end else begin
      state     <= state_next;
      res_valid <= res_valid_next;
      have_pend <= have_pend_next;
      upd       <= upd_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_r_next;
    cnt   <= cnt_next;
    idx   <= idx_next;
    st    <= st_next;
    pend  <= pend_next;
    res   <= res_next;
  end

endmodule

/* design/topic_subscription_dispatcher_core.sv */
// Top level: topic table with subscribe, unsubscribe and publish over one memory port.
// Each slot visit takes a read state and then a check or write state; a subscribe to a full
// topic goes from dispatch straight to its result.
// One transaction at a time: the next command is taken back in idle, while the last result
// is presented. A stalled result holds the walk.
// Reset: control and the per-topic count valid bits clear at once; counts read as zero,
// slot memory is not cleared and no clearing pass is needed.
module topic_subscription_dispatcher_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  tsd_pkg::cmd_t cmd,
  output logic          res_valid,
  input  logic          res_stall,
  output tsd_pkg::res_t res
);

  tsd_pkg::mem_req_t mreq;
  tsd_pkg::mem_rsp_t mrsp;

  tsd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd      (cmd),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res      (res),
    .mreq     (mreq),
    .mrsp     (mrsp)
  );

  tsd_store u_store (
    .clk(clk),
    .rst(rst),
    .req(mreq),
    .rsp(mrsp)
  );

endmodule

/* tb/topic_subscription_dispatcher_core_checker.sv */
// Watches both channels, tracks the topic table and compares every result with its prediction.
module topic_subscription_dispatcher_core_checker
  import tsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  input  logic        cmd_stall,
  input  cmd_t        cmd,
  input  logic        res_valid,
  input  logic        res_stall,
  input  res_t        res,
  output int unsigned fail_count,
  output int unsigned owed_count,
  output int unsigned checked_count,
  output int unsigned delivery_count,
  output int unsigned full_count
);

  slot_t       subs [TOPICS][SUBS_PER_TOPIC];
  int unsigned sub_total [TOPICS];
  res_t        due_results [$];
  int unsigned mismatches = 0;
  int unsigned checked = 0;
  int unsigned deliveries = 0;
  int unsigned fulls = 0;

  function automatic res_t make_result(input logic [2:0] st, input logic [7:0] sid,
                                       input logic [7:0] hid, input logic [15:0] tw,
                                       input logic [31:0] pl, input logic lst);
    res_t r;
    r.status        = st;
    r.subscriber_id = sid;
    r.handler_out   = hid;
    r.topic_out     = tw;
    r.payload_out   = pl;
    r.last          = lst;
    return r;
  endfunction

  function automatic void apply_to_table(input cmd_t c);
    logic [7:0]  tidx;
    logic [7:0]  grp;
    int unsigned n;
    int unsigned hits;
    int unsigned sent_hits;
    int          i;
    int          j;
    bit          found;
    tidx = c.topic[7:0];
    grp  = c.topic[15:8];
    n    = sub_total[tidx];
    case (c.action)
      ACT_SUB: begin
        if (n >= SUBS_PER_TOPIC) begin
          due_results.push_back(make_result(ST_FULL, '0, '0, '0, '0, 1'b1));
        end else begin
          for (i = n; i > 0; i--) subs[tidx][i] = subs[tidx][i-1];
          subs[tidx][0].requester = c.requester_id;
          subs[tidx][0].handler   = c.handler_id;
          subs[tidx][0].grp       = grp;
          sub_total[tidx] = n + 1;
          due_results.push_back(make_result(ST_DONE, '0, '0, '0, '0, 1'b1));
        end
      end
      ACT_UNSUB: begin
        found = 1'b0;
        for (i = 0; i < n && !found; i++) begin
          if (subs[tidx][i].requester == c.requester_id) begin
            found = 1'b1;
            for (j = i; j + 1 < n; j++) subs[tidx][j] = subs[tidx][j+1];
            sub_total[tidx] = n - 1;
          end
        end
        due_results.push_back(make_result(found ? ST_DONE : ST_NOTSUB,
                                          '0, '0, '0, '0, 1'b1));
      end
      ACT_PUB: begin
        hits = 0;
        for (i = 0; i < n; i++)
          if (grp == GRP_ALL || subs[tidx][i].grp == grp) hits++;
        if (hits == 0) begin
          due_results.push_back(make_result(ST_NOMATCH, '0, '0, c.topic, c.payload, 1'b1));
        end else begin
          sent_hits = 0;
          for (i = 0; i < n; i++) begin
            if (grp == GRP_ALL || subs[tidx][i].grp == grp) begin
              sent_hits++;
              due_results.push_back(make_result(ST_DELIV, subs[tidx][i].requester,
                                                subs[tidx][i].handler, c.topic, c.payload,
                                                sent_hits == hits));
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      for (int t = 0; t < TOPICS; t++) sub_total[t] = 0;
      due_results.delete();
    end else begin
      if (cmd_valid && !cmd_stall) apply_to_table(cmd);
      if (res_valid && !res_stall) begin
        checked++;
        if (res.status == ST_DELIV) deliveries++;
        if (res.status == ST_FULL) fulls++;
        if (due_results.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected result st=%0d sid=%02h hid=%02h topic=%04h data=%08h last=%0b",
                     $realtime, res.status, res.subscriber_id, res.handler_out,
                     res.topic_out, res.payload_out, res.last);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          if (res.status !== want.status || res.subscriber_id !== want.subscriber_id ||
              res.handler_out !== want.handler_out || res.topic_out !== want.topic_out ||
              res.payload_out !== want.payload_out || res.last !== want.last) begin
            if (mismatches < 10) begin
              $display("%0t: mismatch exp st=%0d sid=%02h hid=%02h topic=%04h data=%08h last=%0b",
                       $realtime, want.status, want.subscriber_id, want.handler_out,
                       want.topic_out, want.payload_out, want.last);
              $display("%0t:          got st=%0d sid=%02h hid=%02h topic=%04h data=%08h last=%0b",
                       $realtime, res.status, res.subscriber_id, res.handler_out,
                       res.topic_out, res.payload_out, res.last);
            end
            mismatches++;
          end
        end
      end
    end
    fail_count     <= mismatches;
    owed_count     <= due_results.size();
    checked_count  <= checked;
    delivery_count <= deliveries;
    full_count     <= fulls;
  end

endmodule

/* tb/topic_subscription_dispatcher_core_test.sv */
// Testbench top: clock, reset, command stimulus, result back-pressure and the verdict.
module topic_subscription_dispatcher_core_test;
  import tsd_pkg::*;

  localparam logic [1:0] ACT_IGNORED = 2'd3;

  logic        clk;
  logic        rst = 1'b1;
  logic        cmd_valid = 1'b0;
  logic        cmd_stall;
  cmd_t        cmd = '0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  res_t        res;
  bit          quiet = 1'b0;
  int unsigned sent = 0;
  int unsigned fail_count;
  int unsigned owed_count;
  int unsigned checked_count;
  int unsigned delivery_count;
  int unsigned full_count;

  topic_subscription_dispatcher_core DUT (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  topic_subscription_dispatcher_core_checker tally (
    .clk            (clk),
    .rst            (rst),
    .cmd_valid      (cmd_valid),
    .cmd_stall      (cmd_stall),
    .cmd            (cmd),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .res            (res),
    .fail_count     (fail_count),
    .owed_count     (owed_count),
    .checked_count  (checked_count),
    .delivery_count (delivery_count),
    .full_count     (full_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("topic_subscription_dispatcher_core test failed");
    $finish;
  end

  always @(negedge clk) res_stall <= !rst && !quiet && ($urandom_range(0, 99) < 8);

  task automatic send_cmd(input logic [1:0] act, input logic [15:0] tw, input logic [7:0] rq,
                          input logic [7:0] hd, input logic [31:0] pl);
    while (!quiet && $urandom_range(0, 99) < 8) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
    end
    cmd.action       <= act;
    cmd.topic        <= tw;
    cmd.requester_id <= rq;
    cmd.handler_id   <= hd;
    cmd.payload      <= pl;
    cmd_valid        <= 1'b1;
    do @(posedge clk); while (cmd_stall);
    @(negedge clk);
    sent++;
  endtask

  initial begin
    int unsigned real_items;
    int unsigned pick;
    int unsigned sub_w;
    int unsigned k;
    logic [7:0]  tidx;
    logic [7:0]  grp;
    logic [7:0]  rq;
    logic [1:0]  act;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // fill one topic, overflow it, then publish by group and drain
    send_cmd(ACT_SUB,   16'h00FF, 8'h00, 8'hFF, 32'h0);
    send_cmd(ACT_SUB,   16'hFFFF, 8'hFF, 8'h00, 32'hFFFF_FFFF);
    send_cmd(ACT_SUB,   16'h01FF, 8'h11, 8'h22, 32'h0);
    send_cmd(ACT_SUB,   16'h01FF, 8'h11, 8'h33, 32'h0);
    send_cmd(ACT_SUB,   16'h02FF, 8'h44, 8'h55, 32'h0);
    send_cmd(ACT_SUB,   16'h80FF, 8'h66, 8'h77, 32'h0);
    send_cmd(ACT_SUB,   16'h01FF, 8'h88, 8'h99, 32'h0);
    send_cmd(ACT_SUB,   16'h7FFF, 8'hAA, 8'hBB, 32'h0);
    send_cmd(ACT_SUB,   16'h00FF, 8'hCC, 8'hDD, 32'h0);
    send_cmd(ACT_PUB,   16'h00FF, 8'h00, 8'h00, 32'hFFFF_FFFF);
    send_cmd(ACT_PUB,   16'h01FF, 8'hFF, 8'hFF, 32'h0000_0000);
    send_cmd(ACT_PUB,   16'hFFFF, 8'h00, 8'h00, 32'hA5A5_A5A5);
    send_cmd(ACT_PUB,   16'h03FF, 8'h00, 8'h00, 32'h0000_0001);
    send_cmd(ACT_PUB,   16'h0000, 8'h00, 8'h00, 32'h5A5A_5A5A);
    send_cmd(ACT_UNSUB, 16'h00FF, 8'h11, 8'h00, 32'h0);
    send_cmd(ACT_UNSUB, 16'h00FF, 8'h11, 8'h00, 32'h0);
    send_cmd(ACT_UNSUB, 16'h00FF, 8'h11, 8'h00, 32'h0);
    send_cmd(ACT_UNSUB, 16'h0000, 8'h00, 8'h00, 32'h0);
    send_cmd(ACT_IGNORED, 16'hFFFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
    send_cmd(ACT_PUB,   16'h00FF, 8'h00, 8'h00, 32'h1234_5678);
    send_cmd(ACT_UNSUB, 16'h00FF, 8'h00, 8'h00, 32'h0);
    send_cmd(ACT_UNSUB, 16'h00FF, 8'hAA, 8'h00, 32'h0);
    send_cmd(ACT_SUB,   16'h00FF, 8'h01, 8'h02, 32'h0);
    send_cmd(ACT_PUB,   16'h01FF, 8'h00, 8'h00, 32'hDEAD_BEEF);

    // random traffic on a few busy topics; the mix swings between filling and draining
    real_items = 0;
    while (real_items < 235) begin
      quiet = (real_items >= 90 && real_items < 170);
      sub_w = (real_items % 90 < 50) ? 45 : 20;
      pick  = $urandom_range(0, 99);
      if (pick < sub_w) act = ACT_SUB;
      else if (pick < 65) act = ACT_UNSUB;
      else if (pick < 95) act = ACT_PUB;
      else act = ACT_IGNORED;
      k = $urandom_range(0, 2);
      if ($urandom_range(0, 9) < 8) tidx = (k == 0) ? 8'h00 : (k == 1) ? 8'h81 : 8'hFF;
      else tidx = 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 9);
      if (pick < 3) grp = GRP_ALL;
      else if (pick < 8) grp = 8'($urandom_range(1, 3));
      else grp = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 9) < 8) rq = 8'($urandom_range(0, 5));
      else rq = 8'($urandom_range(0, 255));
      send_cmd(act, {grp, tidx}, rq, 8'($urandom_range(0, 255)), $urandom());
      if (act != ACT_IGNORED) real_items++;
    end
    cmd_valid <= 1'b0;
    quiet = 1'b0;

    while (owed_count != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("Sent %0d commands and checked %0d results (%0d deliveries, %0d topic-full replies).",
             sent, checked_count, delivery_count, full_count);
    $display("Mismatches: %0d, results still owed: %0d", fail_count, owed_count);
    if (fail_count == 0 && owed_count == 0) begin
      $display("topic_subscription_dispatcher_core test passed");
    end else begin
      $display("topic_subscription_dispatcher_core test failed");
    end
    $finish;
  end

endmodule
